// ===== rtl/core/grwc_pkg.sv =====
// ----------------------------------------------------------------------------
// grwc_pkg: shared definitions of the grid ray wall caster
// Map geometry, divider and map port types, state and register codes.
// ----------------------------------------------------------------------------
package grwc_pkg;

	localparam int MAP_COLS    = 32;
	localparam int MAP_ROWS    = 16;
	localparam int MAX_COLUMNS = 1024;
	localparam int MAP_CELLS   = MAP_COLS * MAP_ROWS;
	localparam int CELL_AW     = $clog2(MAP_CELLS);

	// walk limit per cast
	localparam int GUARD_N = MAP_COLS + MAP_ROWS + 2;
	localparam int GUARD_W = $clog2(GUARD_N);

	// shared divider: 48 bit dividend, 24 bit divisor, one quotient bit a cycle
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 24;
	localparam int DIV_CW = $clog2(DIV_NW);

	// camera plane length 0.66 in Q.16
	localparam logic signed [16:0] PLANE_Q16 = 17'sd43254;

	localparam int COORD_W = 10;  // cell coordinate, signed
	localparam int RAY_W   = 21;  // ray component, signed Q.16
	localparam int DN_W    = 27;  // grid line offset from player, signed Q.16

	typedef struct packed {
		logic [3:0] wtype;
		logic [2:0] height;
	} cell_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_CAST  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_PLAYER_X      = 3'd0,
		CFG_PLAYER_Y      = 3'd1,
		CFG_DIR_COS       = 3'd2,
		CFG_DIR_SIN       = 3'd3,
		CFG_SCREEN_WIDTH  = 3'd4,
		CFG_SCREEN_HEIGHT = 3'd5,
		CFG_VIEW_TOP      = 3'd6,
		CFG_VIEW_HEIGHT   = 3'd7
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FDIV,
		S_PMUL,
		S_PRND,
		S_RMUL,
		S_RRND,
		S_INIT,
		S_SMUL,
		S_SCMP,
		S_SRD,
		S_TDIV,
		S_HMUL,
		S_HSTART,
		S_HDIV,
		S_BASE,
		S_BDIV,
		S_DONE
	} state_t;

	// v / 2^16, rounded half away from zero
	function automatic logic signed [47:0] round_q16(input logic signed [47:0] v);
		logic [47:0] mag;
		logic [47:0] r;
		begin
			mag = v[47] ? 48'(-v) : 48'(v);
			r   = (mag + 48'd32768) >> 16;
			return v[47] ? -signed'(r) : signed'(r);
		end
	endfunction

endpackage

// ===== rtl/core/grwc_map.sv =====
// ----------------------------------------------------------------------------
// grwc_map: wall cell memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grwc_map (
	input  logic                          clk,
	input  logic                          we,
	input  logic [grwc_pkg::CELL_AW-1:0]  waddr,
	input  grwc_pkg::cell_t               wdata,
	input  logic                          re,
	input  logic [grwc_pkg::CELL_AW-1:0]  raddr,
	output grwc_pkg::cell_t               rdata
);
	import grwc_pkg::*;

	cell_t mem_q [MAP_CELLS];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/grwc_div.sv =====
// ----------------------------------------------------------------------------
// grwc_div: shared unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module grwc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  grwc_pkg::div_req_t  req,
	output grwc_pkg::div_rsp_t  rsp
);
	import grwc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;

	logic [DIV_DW:0]   trial;
	logic              fits;
	logic [DIV_DW-1:0] rem_next;

	assign trial    = {rem_q, num_q[DIV_NW-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign rem_next = fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/core/grid_ray_wall_caster_top.sv =====
// ----------------------------------------------------------------------------
// grid_ray_wall_caster_top: grid ray caster with wall cell map
// Stores wall cells, walks a ray per screen column and reports the wall hit.
// ----------------------------------------------------------------------------
// Usage:
//  - Item channel (item_valid/item_stall): a transfer with command write stores
//    one map cell and gives no result. A transfer with command cast walks a
//    ray for one screen column and gives one result, unless the column is not
//    below screen_width (then nothing comes out).
//  - Result channel (result_valid/result_stall): one transfer per cast.
//  - Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
//  - A cast that hits a wall makes four passes through the shared divider
//    (column factor, distance, hit coordinate, column height) and one map
//    read per grid step of the walk. A ray that leaves the grid skips the last
//    three passes, a zero distance the last one.
//  - One item is worked at a time; item_stall is high while a cast runs.
//    A finished result sits in the output register, so the next item is taken
//    while it waits; a cast that finishes before the old result is taken holds.
//  - Reset clears the controller and loads the register defaults; the map
//    contents are undefined until written.
// ----------------------------------------------------------------------------
module grid_ray_wall_caster_top (
	input  logic               clk,
	input  logic               arst_n,
	// config writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               command,
	input  logic [8:0]         cell_index,
	input  logic [3:0]         cell_type,
	input  logic [2:0]         cell_height,
	input  logic [9:0]         column,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [9:0]         column_out,
	output logic [3:0]         wall_type,
	output logic [2:0]         wall_height,
	output logic [23:0]        distance,
	output logic [15:0]        texture_fraction,
	output logic [15:0]        base_height,
	output logic signed [19:0] wall_row_top,
	output logic signed [19:0] wall_row_end,
	output logic               escaped
);
	import grwc_pkg::*;

	// ---------------- configuration registers ----------------
	logic [23:0]        px_q;
	logic [23:0]        py_q;
	logic signed [15:0] dc_q;
	logic signed [15:0] ds_q;
	logic [10:0]        sw_q;
	logic [9:0]         vt_q;
	logic [10:0]        vh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= 24'd144179;
			py_q <= 24'd275251;
			dc_q <= -16'sd16384;
			ds_q <= 16'sd0;
			sw_q <= 11'd640;
			vt_q <= 10'd380;
			vh_q <= 11'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PLAYER_X:      px_q <= cfg_data;
				CFG_PLAYER_Y:      py_q <= cfg_data;
				CFG_DIR_COS:       dc_q <= signed'(cfg_data[15:0]);
				CFG_DIR_SIN:       ds_q <= signed'(cfg_data[15:0]);
				CFG_SCREEN_WIDTH:  sw_q <= cfg_data[10:0];
				CFG_SCREEN_HEIGHT: ; // clip bound for drawing only, no output uses it
				CFG_VIEW_TOP:      vt_q <= cfg_data[9:0];
				CFG_VIEW_HEIGHT:   vh_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// ---------------- working registers ----------------
	state_t                    state_q, state_d;
	logic [9:0]                col_q;
	logic signed [17:0]        f_q;      // column factor, Q.16
	logic signed [34:0]        pprod_q;
	logic signed [16:0]        p_q;      // plane term, Q.16
	logic signed [32:0]        mx_q, my_q;
	logic signed [RAY_W-1:0]   rx_q, ry_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, nx_q, ny_q;
	logic signed [DN_W-1:0]    dnx_q, dny_q;
	logic [47:0]               pa_q, pb_q;
	logic                      take_q;
	logic [GUARD_W-1:0]        guard_q;
	logic                      esc_q;
	logic [3:0]                wt_q;
	logic [2:0]                wh_q;
	logic [23:0]               t_q;
	logic [47:0]               hmag_q;
	logic                      hneg_q;
	logic [15:0]               frac_q;
	logic [15:0]               base_q;

	// output register
	logic                      out_valid_q;
	logic [9:0]                column_out_q;
	logic [3:0]                wall_type_q;
	logic [2:0]                wall_height_q;
	logic [23:0]               distance_q;
	logic [15:0]               frac_out_q;
	logic [15:0]               base_out_q;
	logic signed [19:0]        start_out_q;
	logic signed [19:0]        end_out_q;
	logic                      esc_out_q;

	// ---------------- map and divider ----------------
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic               mem_we;
	logic               mem_re;
	logic [CELL_AW-1:0] mem_raddr;
	cell_t              mem_wdata;
	cell_t              mem_rdata;

	assign mem_wdata.wtype  = cell_type;
	assign mem_wdata.height = cell_height;

	grwc_map u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cell_index),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	grwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- ray and step datapath ----------------
	logic                      item_acc;
	logic                      cast_ok;
	logic                      rx_neg, ry_neg;
	logic [RAY_W-1:0]          arx, ary;
	logic signed [DN_W-1:0]    dnx, dny;
	logic [DN_W-1:0]           adnx, adny;
	logic                      take_col;
	logic signed [COORD_W-1:0] cx_n, cy_n;
	logic                      next_in_grid;
	logic                      start_in_grid;
	logic                      hit;
	logic signed [DN_W-1:0]    dn_sel;
	logic [DN_W-1:0]           adn_sel;
	logic [RAY_W-1:0]          d_sel, r_oth;
	logic [15:0]               off16;
	logic [15:0]               coord16;
	logic [11:0]               horizon;
	logic [19:0]               end_v;
	logic signed [20:0]        start_v;
	logic [15:0]               base_eff;
	logic [2:0]                wh_eff;
	logic                      out_free;

	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign cast_ok    = (11'(column) < sw_q) && (13'(column) < 13'(MAX_COLUMNS));

	assign rx_neg = rx_q[RAY_W-1];
	assign ry_neg = ry_q[RAY_W-1];
	assign arx    = rx_neg ? RAY_W'(-rx_q) : RAY_W'(rx_q);
	assign ary    = ry_neg ? RAY_W'(-ry_q) : RAY_W'(ry_q);

	// offset of the next grid line from the player, Q.16
	assign dnx  = signed'({nx_q[COORD_W-1], nx_q, 16'h0000}) - signed'(DN_W'(px_q));
	assign dny  = signed'({ny_q[COORD_W-1], ny_q, 16'h0000}) - signed'(DN_W'(py_q));
	assign adnx = dnx[DN_W-1] ? DN_W'(-dnx) : DN_W'(dnx);
	assign adny = dny[DN_W-1] ? DN_W'(-dny) : DN_W'(dny);

	// axis aligned rays walk one kind of crossing; ties go to the column
	always_comb begin
		if (rx_q == '0) begin
			take_col = 1'b0;
		end else if (ry_q == '0) begin
			take_col = 1'b1;
		end else begin
			take_col = pa_q <= pb_q;
		end
	end

	assign cx_n = take_col ? (rx_neg ? cx_q - 1'b1 : cx_q + 1'b1) : cx_q;
	assign cy_n = take_col ? cy_q : (ry_neg ? cy_q - 1'b1 : cy_q + 1'b1);

	assign next_in_grid  = (cx_n >= 0) && (cx_n < signed'(COORD_W'(MAP_COLS)))
	                    && (cy_n >= 0) && (cy_n < signed'(COORD_W'(MAP_ROWS)));
	assign start_in_grid = (cx_q >= 0) && (cx_q < signed'(COORD_W'(MAP_COLS)))
	                    && (cy_q >= 0) && (cy_q < signed'(COORD_W'(MAP_ROWS)));

	assign mem_raddr = CELL_AW'(CELL_AW'(cy_n) * CELL_AW'(MAP_COLS) + CELL_AW'(cx_n));
	assign hit       = (mem_rdata.wtype != 4'd0);

	// hit side selection: column crossing divides by |rx|, row crossing by |ry|
	assign dn_sel  = take_q ? dnx_q : dny_q;
	assign adn_sel = dn_sel[DN_W-1] ? DN_W'(-dn_sel) : DN_W'(dn_sel);
	assign d_sel   = take_q ? arx : ary;
	assign r_oth   = take_q ? ary : arx;

	// floor division: negative quotient rounds away from zero on a remainder
	assign off16   = hneg_q ? 16'(-(div_rsp.quot[15:0] + 16'(div_rsp.rem != '0)))
	                        : div_rsp.quot[15:0];
	assign coord16 = take_q ? py_q[15:0] : px_q[15:0];

	// column extent
	assign horizon  = 12'(vt_q) + 12'(vh_q >> 1);
	assign base_eff = esc_q ? 16'd0 : base_q;
	assign wh_eff   = esc_q ? 3'd0 : wh_q;
	assign end_v    = 20'(horizon) + 20'(base_eff >> 1);
	assign start_v  = signed'(21'(end_v)) - signed'(21'(19'(base_eff) * 19'(wh_eff)));

	assign out_free = !out_valid_q || !result_stall;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					if (cmd_t'(command) == CMD_WRITE) begin
						mem_we = (10'(cell_index) < 10'(MAP_CELLS));
					end else if (cast_ok) begin
						// 2 * column * 2^16 / screen_width
						div_req.start = 1'b1;
						div_req.num   = DIV_NW'({column, 17'h00000});
						div_req.den   = DIV_DW'(sw_q);
						state_d       = S_FDIV;
					end
				end
			end
			S_FDIV:   if (div_rsp.done) state_d = S_PMUL;
			S_PMUL:   state_d = S_PRND;
			S_PRND:   state_d = S_RMUL;
			S_RMUL:   state_d = S_RRND;
			S_RRND:   state_d = S_INIT;
			S_INIT: begin
				if ((rx_q == '0 && ry_q == '0) || !start_in_grid) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SMUL;
				end
			end
			S_SMUL:   state_d = S_SCMP;
			S_SCMP: begin
				if (next_in_grid) begin
					mem_re  = 1'b1;
					state_d = S_SRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRD: begin
				if (hit) begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'({adn_sel, 16'h0000});
					div_req.den   = DIV_DW'(d_sel);
					state_d       = S_TDIV;
				end else if (guard_q == GUARD_W'(GUARD_N - 1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SMUL;
				end
			end
			S_TDIV:   if (div_rsp.done) state_d = S_HMUL;
			S_HMUL:   state_d = S_HSTART;
			S_HSTART: begin
				div_req.start = 1'b1;
				div_req.num   = hmag_q;
				div_req.den   = DIV_DW'(d_sel);
				state_d       = S_HDIV;
			end
			S_HDIV:   if (div_rsp.done) state_d = S_BASE;
			S_BASE: begin
				if (t_q == '0) begin
					state_d = S_DONE;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'({vh_q, 16'h0000});
					div_req.den   = t_q;
					state_d       = S_BDIV;
				end
			end
			S_BDIV:   if (div_rsp.done) state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath registers, updated by the step in progress
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					col_q   <= column;
					esc_q   <= 1'b1;
					guard_q <= '0;
				end
			end
			S_FDIV: begin
				if (div_rsp.done) begin
					f_q <= signed'(18'(div_rsp.quot[17:0] - 18'h10000));
				end
			end
			S_PMUL: pprod_q <= PLANE_Q16 * f_q;
			S_PRND: p_q <= 17'(round_q16(48'(pprod_q)));
			S_RMUL: begin
				mx_q <= ds_q * p_q;
				my_q <= dc_q * p_q;
			end
			S_RRND: begin
				rx_q <= (RAY_W'(dc_q) <<< 2) - RAY_W'(round_q16(48'(mx_q) <<< 2));
				ry_q <= (RAY_W'(ds_q) <<< 2) + RAY_W'(round_q16(48'(my_q) <<< 2));
				cx_q <= signed'(COORD_W'(px_q[23:16]));
				cy_q <= signed'(COORD_W'(py_q[23:16]));
			end
			S_INIT: begin
				nx_q <= rx_neg ? cx_q : cx_q + 1'b1;
				ny_q <= ry_neg ? cy_q : cy_q + 1'b1;
			end
			S_SMUL: begin
				dnx_q <= dnx;
				dny_q <= dny;
				pa_q  <= 48'(adnx) * 48'(ary);
				pb_q  <= 48'(adny) * 48'(arx);
			end
			S_SCMP: begin
				take_q <= take_col;
				cx_q   <= cx_n;
				cy_q   <= cy_n;
			end
			S_SRD: begin
				if (hit) begin
					wt_q  <= mem_rdata.wtype;
					wh_q  <= mem_rdata.height;
					esc_q <= 1'b0;
				end else begin
					guard_q <= guard_q + 1'b1;
					if (take_q) begin
						nx_q <= rx_neg ? nx_q - 1'b1 : nx_q + 1'b1;
					end else begin
						ny_q <= ry_neg ? ny_q - 1'b1 : ny_q + 1'b1;
					end
				end
			end
			S_TDIV: begin
				if (div_rsp.done) begin
					t_q <= (div_rsp.quot[47:24] != '0) ? 24'hFFFFFF : div_rsp.quot[23:0];
				end
			end
			S_HMUL: begin
				hmag_q <= 48'(adn_sel) * 48'(r_oth);
				hneg_q <= dn_sel[DN_W-1] ^ rx_neg ^ ry_neg;
			end
			S_HDIV: begin
				if (div_rsp.done) begin
					frac_q <= coord16 + off16;
				end
			end
			S_BASE: begin
				if (t_q == '0) begin
					base_q <= 16'hFFFF;
				end
			end
			S_BDIV: begin
				if (div_rsp.done) begin
					base_q <= (div_rsp.quot[47:16] != '0) ? 16'hFFFF : div_rsp.quot[15:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			column_out_q  <= col_q;
			wall_type_q   <= esc_q ? 4'd0 : wt_q;
			wall_height_q <= wh_eff;
			distance_q    <= esc_q ? 24'hFFFFFF : t_q;
			frac_out_q    <= esc_q ? 16'd0 : frac_q;
			base_out_q    <= base_eff;
			start_out_q   <= start_v[19:0];
			end_out_q     <= signed'(end_v);
			esc_out_q     <= esc_q;
		end
	end

	assign result_valid     = out_valid_q;
	assign column_out       = column_out_q;
	assign wall_type        = wall_type_q;
	assign wall_height      = wall_height_q;
	assign distance         = distance_q;
	assign texture_fraction = frac_out_q;
	assign base_height      = base_out_q;
	assign wall_row_top     = start_out_q;
	assign wall_row_end     = end_out_q;
	assign escaped          = esc_out_q;

`ifndef SYNTHESIS
	// divider answers only arrive while the sequencer waits for one
	ap_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_FDIV || state_q == S_TDIV
			|| state_q == S_HDIV || state_q == S_BDIV))
		else $error("divider result outside a wait state");

	// map data is examined in the cycle after its read
	ap_map_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRD |-> $past(state_q) == S_SCMP)
		else $error("map data used without a read the cycle before");

	// escaped results carry the fixed miss values
	ap_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && escaped) |-> (distance == 24'hFFFFFF && wall_type == 4'd0
			&& wall_row_top == wall_row_end))
		else $error("escaped result with hit data");

	// a hit always names a wall cell
	ap_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !escaped) |-> wall_type != 4'd0)
		else $error("hit result on an empty cell");
`endif

endmodule

// ===== tb/grid_ray_wall_caster_checker.sv =====
// ----------------------------------------------------------------------------
// grid_ray_wall_caster_checker: result predictor and scoreboard
// Watches the config, item and result channels, predicts each cast result
// from its own map and register copy and compares the results field by field.
// ----------------------------------------------------------------------------
module grid_ray_wall_caster_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic        command,
	input  logic [8:0]  cell_index,
	input  logic [3:0]  cell_type,
	input  logic [2:0]  cell_height,
	input  logic [9:0]  column,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [9:0]  column_out,
	input  logic [3:0]  wall_type,
	input  logic [2:0]  wall_height,
	input  logic [23:0] distance,
	input  logic [15:0] texture_fraction,
	input  logic [15:0] base_height,
	input  logic [19:0] wall_row_top,
	input  logic [19:0] wall_row_end,
	input  logic        escaped,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import grwc_pkg::*;

	typedef struct packed {
		logic [9:0]  col;
		logic [3:0]  wtype;
		logic [2:0]  wheight;
		logic [23:0] wdist;
		logic [15:0] tex;
		logic [15:0] base;
		logic [19:0] cstart;
		logic [19:0] cend;
		logic        esc;
	} hit_t;

	logic [3:0] map_type [MAP_CELLS];
	logic [2:0] map_ht [MAP_CELLS];

	logic [23:0] pos_x, pos_y;
	logic signed [15:0] cos_q, sin_q;
	logic [10:0] scr_w, scr_h, vw_h;
	logic [9:0]  vw_top;

	hit_t hits_due [$];

	function automatic longint rnd16(longint v);
		if (v >= 0)
			return (v + 32768) / 65536;
		return -((-v + 32768) / 65536);
	endfunction

	function automatic longint fdiv(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit on_map(longint x, longint y);
		return x >= 0 && x < MAP_COLS && y >= 0 && y < MAP_ROWS;
	endfunction

	// walk one ray and build the expected column result
	function automatic hit_t cast_ray(logic [9:0] c);
		hit_t h;
		longint px, py, hor, f, p, rx, ry, arx, ary, sx, sy, cx, cy, nx, ny;
		longint dx, dy, t, hw, n, d, base, cend;
		bit take_col, hit;
		int idx;
		px = longint'(pos_x);
		py = longint'(pos_y);
		hor = longint'(vw_top) + longint'(vw_h) / 2;
		f = (2 * longint'(c) * 65536) / longint'(scr_w) - 65536;
		p = rnd16(43254 * f);
		rx = 4 * longint'(cos_q) - rnd16(4 * longint'(sin_q) * p);
		ry = 4 * longint'(sin_q) + rnd16(4 * longint'(cos_q) * p);
		arx = mag(rx);
		ary = mag(ry);
		sx = rx < 0 ? -1 : 1;
		sy = ry < 0 ? -1 : 1;
		cx = px / 65536;
		cy = py / 65536;
		nx = sx > 0 ? cx + 1 : cx;
		ny = sy > 0 ? cy + 1 : cy;
		hit = 0;
		t = 0;
		hw = 0;
		h = '0;
		h.col = c;
		if ((rx != 0 || ry != 0) && on_map(cx, cy)) begin
			for (int g = 0; g < GUARD_N; g++) begin
				dx = mag(nx * 65536 - px);
				dy = mag(ny * 65536 - py);
				if (rx == 0)
					take_col = 0;
				else if (ry == 0)
					take_col = 1;
				else
					take_col = dx * ary <= dy * arx;  // ties go to the column line
				if (take_col)
					cx += sx;
				else
					cy += sy;
				if (!on_map(cx, cy))
					break;
				idx = int'(cy * MAP_COLS + cx);
				if (map_type[idx] != 0) begin
					hit = 1;
					h.wtype = map_type[idx];
					h.wheight = map_ht[idx];
					if (take_col) begin
						t = dx * 65536 / arx;
						n = (nx * 65536 - px) * ry;
						d = rx;
						if (d < 0) begin
							n = -n;
							d = -d;
						end
						hw = py + fdiv(n, d);
					end else begin
						t = dy * 65536 / ary;
						n = (ny * 65536 - py) * rx;
						d = ry;
						if (d < 0) begin
							n = -n;
							d = -d;
						end
						hw = px + fdiv(n, d);
					end
					break;
				end
				if (take_col)
					nx += sx;
				else
					ny += sy;
			end
		end
		h.esc = !hit;
		if (!hit) begin
			h.wdist = 24'hFFFFFF;
			h.cstart = hor[19:0];
			h.cend = hor[19:0];
		end else begin
			if (t > 24'hFFFFFF)
				t = 24'hFFFFFF;
			if (t == 0)
				base = 65535;
			else begin
				base = (longint'(vw_h) * 65536) / t;
				if (base > 65535)
					base = 65535;
			end
			cend = hor + base / 2;
			h.wdist = t[23:0];
			h.tex = hw[15:0];
			h.base = base[15:0];
			h.cend = cend[19:0];
			h.cstart = 20'(cend - base * longint'(h.wheight));
		end
		return h;
	endfunction

	function automatic int field_bad(string name, logic [23:0] exp_v, logic [23:0] got_v);
		if (exp_v === got_v)
			return 0;
		$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
		return 1;
	endfunction

	// Sample at the falling edge: a transfer seen here completes at the next rise.
	always @(negedge clk or negedge arst_n) begin
		hit_t want;
		int bad;
		if (!arst_n) begin
			pos_x = 24'd144179;
			pos_y = 24'd275251;
			cos_q = -16'sd16384;
			sin_q = 16'sd0;
			scr_w = 11'd640;
			scr_h = 11'd480;
			vw_top = 10'd380;
			vw_h = 11'd100;
			fail_count = 0;
			hits_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PLAYER_X:      pos_x = cfg_data;
					CFG_PLAYER_Y:      pos_y = cfg_data;
					CFG_DIR_COS:       cos_q = cfg_data[15:0];
					CFG_DIR_SIN:       sin_q = cfg_data[15:0];
					CFG_SCREEN_WIDTH:  scr_w = cfg_data[10:0];
					CFG_SCREEN_HEIGHT: scr_h = cfg_data[10:0];
					CFG_VIEW_TOP:      vw_top = cfg_data[9:0];
					CFG_VIEW_HEIGHT:   vw_h = cfg_data[10:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				if (cmd_t'(command) == CMD_WRITE) begin
					if (cell_index < MAP_CELLS) begin
						map_type[cell_index] = cell_type;
						map_ht[cell_index] = cell_height;
					end
				end else if (column < scr_w && column < MAX_COLUMNS) begin
					hits_due.push_back(cast_ray(column));
				end
			end
			if (result_valid && !result_stall) begin
				if (hits_due.size() == 0) begin
					$display("%0t: unexpected result for column %0d", $time, column_out);
					fail_count++;
				end else begin
					want = hits_due.pop_front();
					bad = field_bad("column_out", want.col, column_out)
						+ field_bad("wall_type", want.wtype, wall_type)
						+ field_bad("wall_height", want.wheight, wall_height)
						+ field_bad("distance", want.wdist, distance)
						+ field_bad("texture_fraction", want.tex, texture_fraction)
						+ field_bad("base_height", want.base, base_height)
						+ field_bad("wall_row_top", want.cstart, wall_row_top)
						+ field_bad("wall_row_end", want.cend, wall_row_end)
						+ field_bad("escaped", want.esc, escaped);
					if (bad != 0)
						fail_count++;
				end
			end
			pending = hits_due.size();
		end
	end

endmodule

// ===== tb/grid_ray_wall_caster_top_tb.sv =====
// ----------------------------------------------------------------------------
// grid_ray_wall_caster_top_tb: stimulus and verdict for the grid ray caster
// Fills the map, runs directed and random casts over several view settings
// with random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module grid_ray_wall_caster_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import grwc_pkg::*;

	localparam int SETTLE = 700;  // cycles past a cast that gives no result

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        command = 1'b0;
	logic [8:0]  cell_index = '0;
	logic [3:0]  cell_type = '0;
	logic [2:0]  cell_height = '0;
	logic [9:0]  column = '0;

	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [9:0]         column_out;
	logic [3:0]         wall_type;
	logic [2:0]         wall_height;
	logic [23:0]        distance;
	logic [15:0]        texture_fraction;
	logic [15:0]        base_height;
	logic signed [19:0] wall_row_top;
	logic signed [19:0] wall_row_end;
	logic               escaped;

	int fail_count;
	int pending;

	// idle odds in percent per cycle, set per phase
	int send_idle = 6;
	int recv_idle = 46;
	bit hold_results = 1'b0;
	int width_now = 640;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	grid_ray_wall_caster_top dut (.*);

	grid_ray_wall_caster_checker chk (.*);

	// Receiver: random stall, forced high during the hold-off stretch.
	always @(posedge clk)
		result_stall <= hold_results || ($urandom_range(0, 99) < recv_idle);

	// Long hold-off: the block keeps one result and one item, then stalls input.
	initial begin
		wait (arst_n);
		repeat (30000) @(posedge clk);
		hold_results = 1'b1;
		repeat (4000) @(posedge clk);
		hold_results = 1'b0;
	end

	initial begin
		#15_000_000;
		$display("FAIL");
		$finish;
	end

	// One register write; the caller drops cfg_valid after its last write.
	task automatic cfg_write(cfg_reg_t idx, logic [23:0] val);
		bit done;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			done = cfg_ready;
			@(posedge clk);
		end while (!done);
		if (idx == CFG_SCREEN_WIDTH)
			width_now = int'(val);
	endtask

	// One item transfer; valid stays up into the next item when no gap is drawn.
	task automatic send_item(cmd_t cmd, logic [8:0] idx, logic [3:0] ty, logic [2:0] ht,
			logic [9:0] col);
		bit done;
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		cell_index <= idx;
		cell_type <= ty;
		cell_height <= ht;
		column <= col;
		do begin
			@(negedge clk);
			done = !item_stall;
			@(posedge clk);
		end while (!done);
	endtask

	task automatic cast(logic [9:0] col);
		send_item(CMD_CAST, 9'($urandom), 4'($urandom), 3'($urandom), col);
	endtask

	task automatic write_cell(logic [8:0] idx, logic [3:0] ty, logic [2:0] ht);
		send_item(CMD_WRITE, idx, ty, ht, 10'($urandom));
	endtask

	// Wait until the block is idle: results drained and stray casts finished.
	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic view(logic [23:0] x, logic [23:0] y, logic signed [15:0] c,
			logic signed [15:0] s, logic [10:0] w, logic [10:0] sh, logic [9:0] vt,
			logic [10:0] vh);
		drain();
		cfg_write(CFG_PLAYER_X, x);
		cfg_write(CFG_PLAYER_Y, y);
		cfg_write(CFG_DIR_COS, 24'(c));
		cfg_write(CFG_DIR_SIN, 24'(s));
		cfg_write(CFG_SCREEN_WIDTH, 24'(w));
		cfg_write(CFG_SCREEN_HEIGHT, 24'(sh));
		cfg_write(CFG_VIEW_TOP, 24'(vt));
		cfg_write(CFG_VIEW_HEIGHT, 24'(vh));
		cfg_valid <= 1'b0;
	endtask

	// Mostly casts on the screen, some writes, a few columns past the edge.
	task automatic random_items(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				write_cell(9'($urandom), ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd0,
					3'($urandom));
			else if (r < 15)
				cast(10'($urandom));
			else
				cast(10'($urandom_range(0, width_now - 1)));
		end
	endtask

	initial begin
		int seeded_cell;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every cell gets written before any ray can read it.
		for (int i = 0; i < MAP_CELLS; i++) begin
			seeded_cell = $urandom_range(0, 99);
			write_cell(9'(i), (seeded_cell < 30) ? 4'($urandom_range(1, 15)) : 4'd0,
				3'($urandom));
		end

		// Directed part at reset view: screen edges, center (axis aligned ray),
		// columns past the edge, extreme cell values.
		write_cell(9'd0, 4'd15, 3'd7);
		write_cell(9'd511, 4'd0, 3'd0);
		write_cell(9'd70, 4'd1, 3'd0);
		cast(10'd0);
		cast(10'd639);
		cast(10'd320);
		cast(10'd640);
		cast(10'd1023);

		// Diagonal from a cell center at the screen center: equal crossings.
		view(24'h058000, 24'h058000, 16'sd11585, 16'sd11585, 11'd1024, 11'd1024,
			10'd1023, 11'd1024);
		cast(10'd512);
		cast(10'd0);
		cast(10'd1023);
		// Zero direction: no ray at all.
		view(24'h038000, 24'h048000, 16'sd0, 16'sd0, 11'd1, 11'd1, 10'd0, 11'd1);
		cast(10'd0);
		cast(10'd1);
		// Player cell far outside the grid.
		view(24'hFFFFFF, 24'hFFFFFF, 16'sd16384, 16'sd0, 11'd640, 11'd480, 10'd380,
			11'd100);
		cast(10'd100);
		cast(10'd320);
		// Player on a cell corner facing straight up the map.
		view(24'h000000, 24'h000000, 16'sd0, 16'sd16384, 11'd640, 11'd480, 10'd0,
			11'd1024);
		cast(10'd320);
		cast(10'd639);

		// Random phases over several views, idling swapped then off.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle = 46;
				recv_idle = 6;
			end else if (ph == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			view(24'($urandom_range(65536, 32 * 65536 - 1)),
				24'($urandom_range(65536, 16 * 65536 - 1)),
				16'($signed($urandom_range(0, 32768)) - 16384),
				16'($signed($urandom_range(0, 32768)) - 16384),
				(ph == 5) ? 11'd1024 : 11'($urandom_range(2, 1024)),
				11'($urandom_range(1, 1024)), 10'($urandom), 11'($urandom_range(1, 1024)));
			random_items(170);
		end

		drain();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/grwc_pkg.sv
rtl/core/grwc_map.sv
rtl/core/grwc_div.sv
rtl/core/grid_ray_wall_caster_top.sv
tb/grid_ray_wall_caster_checker.sv
tb/grid_ray_wall_caster_top_tb.sv
